/* hdl/rthc_pkg.sv */
// Shared constants and types for the RGB to HSV converter.
`default_nettype none

package rthc_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 8;
    localparam int HUE_BITS          = HUE_FRACTION_BITS + 3;

    // The divider yields enough quotient bits for both the saturation and the hue fraction.
    localparam int QUO_BITS = (CHANNEL_BITS > HUE_FRACTION_BITS + 1) ?
                              CHANNEL_BITS : HUE_FRACTION_BITS + 1;
    localparam int NUM_BITS = CHANNEL_BITS + QUO_BITS;

    localparam logic [HUE_BITS-1:0] HUE_ONE  = HUE_BITS'(1) << HUE_FRACTION_BITS;
    localparam logic [HUE_BITS-1:0] HUE_TWO  = HUE_ONE << 1;
    localparam logic [HUE_BITS-1:0] HUE_FOUR = HUE_ONE << 2;
    localparam logic [HUE_BITS-1:0] HUE_TURN = HUE_TWO + HUE_FOUR;

    typedef logic [1:0] sector_t;

    localparam sector_t SECTOR_RED   = 2'd0;
    localparam sector_t SECTOR_GREEN = 2'd1;
    localparam sector_t SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        sector_t                 sector;
        logic                    neg;
        logic                    defined;
        logic [CHANNEL_BITS-1:0] max;
        logic [CHANNEL_BITS-1:0] alpha;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [CHANNEL_BITS-1:0] delta;
        logic [CHANNEL_BITS-1:0] diff_mag;
    } front_t;

endpackage

`default_nettype wire

/* hdl/rthc_front.sv */
// Input stage: maximum, minimum, sector choice and hue difference of one pixel.
`default_nettype none

module rthc_front (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               advance,
    input  wire                               in_valid,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] red,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] green,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] blue,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] opacity_in,
    output logic                              front_valid,
    output rthc_pkg::front_t                  front
);

    logic                              valid_reg;
    rthc_pkg::front_t                  front_reg;
    rthc_pkg::front_t                  front_next;
    logic [rthc_pkg::CHANNEL_BITS-1:0] mx;
    logic [rthc_pkg::CHANNEL_BITS-1:0] mn;
    logic [rthc_pkg::CHANNEL_BITS-1:0] op_a;
    logic [rthc_pkg::CHANNEL_BITS-1:0] op_b;
    logic [rthc_pkg::CHANNEL_BITS:0]   diff;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end

        // Ties go to red, then green.
        if (red >= green && red >= blue)
        begin
            front_next.side.sector = rthc_pkg::SECTOR_RED;
            op_a = green;
            op_b = blue;
        end
        else if (green >= blue)
        begin
            front_next.side.sector = rthc_pkg::SECTOR_GREEN;
            op_a = blue;
            op_b = red;
        end
        else
        begin
            front_next.side.sector = rthc_pkg::SECTOR_BLUE;
            op_a = red;
            op_b = green;
        end

        diff = {1'b0, op_a} - {1'b0, op_b};
        front_next.side.neg     = diff[rthc_pkg::CHANNEL_BITS];
        front_next.side.defined = (mx != '0);
        front_next.side.max     = mx;
        front_next.side.alpha   = opacity_in;
        front_next.delta        = mx - mn;
        front_next.diff_mag     = diff[rthc_pkg::CHANNEL_BITS] ?
                                  rthc_pkg::CHANNEL_BITS'(-diff) :
                                  diff[rthc_pkg::CHANNEL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
        end
    end

    assign front_valid = valid_reg;
    assign front       = front_reg;

endmodule

`default_nettype wire

/* hdl/rthc_div.sv */
// Pipelined restoring divider that retires one quotient bit per stage.
`default_nettype none

module rthc_div (
    input  wire                               clk,
    input  wire                               advance,
    input  wire  [rthc_pkg::NUM_BITS-1:0]     num,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] den,
    output logic [rthc_pkg::QUO_BITS-1:0]     quo
);

    localparam int CB = rthc_pkg::CHANNEL_BITS;
    localparam int QB = rthc_pkg::QUO_BITS;

    // The shift word starts with the low numerator bits and fills with quotient bits.
    logic [CB-1:0] rem_reg  [QB];
    logic [QB-1:0] sh_reg   [QB];
    logic [CB-1:0] den_reg  [QB];
    logic [CB-1:0] rem_next [QB];
    logic [QB-1:0] sh_next  [QB];

    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_stage
            logic [CB-1:0] rem_in;
            logic [QB-1:0] sh_in;
            logic [CB-1:0] den_in;
            logic [CB:0]   trial;
            logic          ge;

            if (s == 0)
            begin : g_first
                assign rem_in = num[rthc_pkg::NUM_BITS-1:QB];
                assign sh_in  = num[QB-1:0];
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign sh_in  = sh_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            always_comb
            begin
                trial       = {rem_in, sh_in[QB-1]};
                ge          = (trial >= {1'b0, den_in});
                rem_next[s] = ge ? CB'(trial - {1'b0, den_in}) : trial[CB-1:0];
                sh_next[s]  = {sh_in[QB-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[s] <= rem_next[s];
                    sh_reg[s]  <= sh_next[s];
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = sh_reg[QB-1];

endmodule

`default_nettype wire

/* hdl/rthc_back.sv */
// Output stage: hue assembly from sector and fraction, and the output register.
`default_nettype none

module rthc_back (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               advance,
    input  wire                               side_valid,
    input  wire  rthc_pkg::side_t             side,
    input  wire  [rthc_pkg::QUO_BITS-1:0]     sat_quo,
    input  wire  [rthc_pkg::QUO_BITS-1:0]     hue_quo,
    output logic                              out_valid,
    output logic [rthc_pkg::HUE_BITS-1:0]     hue,
    output logic                              hue_defined,
    output logic [rthc_pkg::CHANNEL_BITS-1:0] saturation,
    output logic [rthc_pkg::CHANNEL_BITS-1:0] brightness,
    output logic [rthc_pkg::CHANNEL_BITS-1:0] opacity_out
);

    logic                              valid_reg;
    logic [rthc_pkg::HUE_BITS-1:0]     hue_reg;
    logic [rthc_pkg::HUE_BITS-1:0]     hue_next;
    logic                              defined_reg;
    logic [rthc_pkg::CHANNEL_BITS-1:0] sat_reg;
    logic [rthc_pkg::CHANNEL_BITS-1:0] sat_next;
    logic [rthc_pkg::CHANNEL_BITS-1:0] bright_reg;
    logic [rthc_pkg::CHANNEL_BITS-1:0] alpha_reg;
    logic [rthc_pkg::HUE_BITS-1:0]     base;
    logic [rthc_pkg::HUE_BITS-1:0]     frac;

    always_comb
    begin
        frac = rthc_pkg::HUE_BITS'(hue_quo[rthc_pkg::HUE_FRACTION_BITS:0]);
        case (side.sector)
            rthc_pkg::SECTOR_RED:
            begin
                // A negative red hue wraps around by one full turn.
                base = (side.neg && frac != '0) ? rthc_pkg::HUE_TURN : '0;
            end
            rthc_pkg::SECTOR_GREEN:
            begin
                base = rthc_pkg::HUE_TWO;
            end
            rthc_pkg::SECTOR_BLUE:
            begin
                base = rthc_pkg::HUE_FOUR;
            end
            default:
            begin
                base = '0;
            end
        endcase

        if (!side.defined)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = side.neg ? base - frac : base + frac;
            sat_next = sat_quo[rthc_pkg::CHANNEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= side_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg     <= hue_next;
            defined_reg <= side.defined;
            sat_reg     <= sat_next;
            bright_reg  <= side.max;
            alpha_reg   <= side.alpha;
        end
    end

    assign out_valid   = valid_reg;
    assign hue         = hue_reg;
    assign hue_defined = defined_reg;
    assign saturation  = sat_reg;
    assign brightness  = bright_reg;
    assign opacity_out = alpha_reg;

endmodule

`default_nettype wire

/* hdl/rgb_to_hsv_converter.sv */
// Top level of the pipelined RGB to HSV pixel converter.
//
// Takes one pixel per clock while in_stall is low and returns one HSV beat per pixel, in
// order, through one input stage for maximum, minimum and sector, one stage per quotient
// bit in the two parallel restoring dividers (saturation and hue fraction), and the
// output register. Hue runs from 0 to 1535 for a full turn; a black pixel gives
// hue_defined low with hue and saturation zero, a grey pixel gives hue zero. The whole
// pipeline holds while out_stall is high and a result is waiting; in_stall follows that
// condition in the same cycle.
`default_nettype none

module rgb_to_hsv_converter (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] red,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] green,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] blue,
    input  wire  [rthc_pkg::CHANNEL_BITS-1:0] opacity_in,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [rthc_pkg::HUE_BITS-1:0]     hue,
    output logic                              hue_defined,
    output logic [rthc_pkg::CHANNEL_BITS-1:0] saturation,
    output logic [rthc_pkg::CHANNEL_BITS-1:0] brightness,
    output logic [rthc_pkg::CHANNEL_BITS-1:0] opacity_out
);

    localparam int CB = rthc_pkg::CHANNEL_BITS;
    localparam int QB = rthc_pkg::QUO_BITS;
    localparam int NB = rthc_pkg::NUM_BITS;

    logic                  advance;
    logic                  front_valid;
    rthc_pkg::front_t      front;
    logic [NB-1:0]         sat_num;
    logic [CB-1:0]         sat_den;
    logic [NB-1:0]         hue_num;
    logic [CB-1:0]         hue_den;
    logic [QB-1:0]         sat_quo;
    logic [QB-1:0]         hue_quo;
    logic                  side_valid_reg [QB];
    rthc_pkg::side_t       side_reg       [QB];

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    rthc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .opacity_in  (opacity_in),
        .front_valid (front_valid),
        .front       (front)
    );

    // Zero divisors only occur where the numerator is zero too; a divisor of one keeps
    // the quotient at zero there.
    always_comb
    begin
        sat_num = NB'({front.delta, {CB{1'b0}}}) - NB'(front.delta);
        sat_den = (front.side.max == '0) ? CB'(1) : front.side.max;
        hue_num = NB'({front.diff_mag, {rthc_pkg::HUE_FRACTION_BITS{1'b0}}});
        hue_den = (front.delta == '0) ? CB'(1) : front.delta;
    end

    rthc_div u_sat_div (
        .clk     (clk),
        .advance (advance),
        .num     (sat_num),
        .den     (sat_den),
        .quo     (sat_quo)
    );

    rthc_div u_hue_div (
        .clk     (clk),
        .advance (advance),
        .num     (hue_num),
        .den     (hue_den),
        .quo     (hue_quo)
    );

    // Sector, sign and pass-through fields ride alongside the divider stages.
    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_valid_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    side_valid_reg[s] <= (s == 0) ? front_valid : side_valid_reg[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    side_reg[s] <= (s == 0) ? front.side : side_reg[(s == 0) ? 0 : s-1];
                end
            end
        end
    endgenerate

    rthc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .side_valid  (side_valid_reg[QB-1]),
        .side        (side_reg[QB-1]),
        .sat_quo     (sat_quo),
        .hue_quo     (hue_quo),
        .out_valid   (out_valid),
        .hue         (hue),
        .hue_defined (hue_defined),
        .saturation  (saturation),
        .brightness  (brightness),
        .opacity_out (opacity_out)
    );

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < rthc_pkg::HUE_TURN)
        else $error("hue beyond a full turn");

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hue_defined |-> hue == '0 && saturation == '0)
        else $error("black pixel with nonzero hue or saturation");

    a_defined_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (brightness == '0) == !hue_defined)
        else $error("hue_defined disagrees with brightness");

    a_sat_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == '0 && hue_defined |-> hue == '0)
        else $error("grey pixel with nonzero hue");

endmodule

`default_nettype wire
